// File: src/dplru_pkg.sv
// Shared types and constants of the degree-priority LRU replacement engine.
package dplru_pkg;

  localparam int unsigned DEG_W   = 4;
  localparam int unsigned STAMP_W = 32;
  localparam int unsigned ENTRY_W = DEG_W + STAMP_W;
  localparam int unsigned KIND_W  = 3;
  localparam int unsigned SET_W   = 6;
  localparam int unsigned WAY_W   = 3;

  typedef enum logic [KIND_W-1:0] {
    KIND_TOUCH       = 3'd0,
    KIND_FILL        = 3'd1,
    KIND_INVALIDATE  = 3'd2,
    KIND_SET_DEGREE  = 3'd3,
    KIND_FIND_VICTIM = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_PUSH
  } state_e;

endpackage

// File: src/degree_priority_lru_victim.sv
// Degree-priority LRU replacement engine: top level with set memory and victim scan.
//
// Requests arrive on the s_axis channel: tuser carries the operation kind and tdata the
// set, way, new degree and current tick. Each request gives exactly one result on the
// m_axis channel: the victim way (find victim only, otherwise zero) and the degree the
// addressed way held before the request.
// Each set is one row of the state memory, holding degree and stamp of every way. A
// request reads its row in the cycle after acceptance and, for an update, writes the
// modified row back in that cycle. A find victim walks the row one way per cycle.
// Requests are taken one at a time, because of the single shared row read and the
// one-comparator victim scan: a new request is accepted only once the last one has
// handed its result to the output register.
// After reset the block clears the memory, one row per cycle, and holds s_axis_tready
// low meanwhile.
// The result sits in an output register; a stalled receiver holds it there, and a new
// request may already be accepted and worked on, waiting only to hand its result over.
module degree_priority_lru_victim #(
  parameter int unsigned WAYS = 8,
  parameter int unsigned SETS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [5:0] set_index, [8:6] way_index, [12:9] new_degree, [44:13] now_tick, rest zero
  input  logic [47:0] s_axis_tdata_i,
  // [2:0] kind
  input  logic [2:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [2:0] victim_way, [6:3] old_degree, [7] zero
  output logic [7:0]  m_axis_tdata_o
);

  localparam int unsigned AW    = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int unsigned WIW   = $clog2(WAYS);
  localparam int unsigned ROW_W = WAYS * dplru_pkg::ENTRY_W;
  localparam int unsigned DW    = dplru_pkg::DEG_W;
  localparam int unsigned SW    = dplru_pkg::STAMP_W;
  localparam int unsigned EW    = dplru_pkg::ENTRY_W;

  dplru_pkg::state_e state_q, state_d;

  logic                          accept;
  logic                          slot_free;
  logic [dplru_pkg::SET_W-1:0]   in_set;
  logic [dplru_pkg::WAY_W-1:0]   in_way;

  dplru_pkg::kind_e              kind_q;
  logic [AW-1:0]                 set_q;
  logic                          set_ok_q;
  logic                          way_ok_q;
  logic [WIW-1:0]                way_q;
  logic [DW-1:0]                 deg_q;
  logic [SW-1:0]                 tick_q;

  logic [WIW-1:0]                best_q, best_d;
  logic [WIW-1:0]                cnt_q, cnt_d;
  logic [AW-1:0]                 clr_q, clr_d;
  logic [dplru_pkg::WAY_W-1:0]   res_vic_q, res_vic_d;
  logic [DW-1:0]                 res_old_q, res_old_d;

  logic                          m_valid_q, m_valid_d;
  logic [7:0]                    m_data_q, m_data_d;

  logic [ROW_W-1:0]              row;
  logic [ROW_W-1:0]              new_row;
  logic [ROW_W-1:0]              wdata;
  logic [AW-1:0]                 waddr;
  logic                          we;
  logic                          upd_we;
  logic                          better;
  logic                          scan_last;
  logic [DW-1:0]                 cand_deg, best_deg;
  logic [SW-1:0]                 cand_stamp, best_stamp;

  assign in_set    = s_axis_tdata_i[5:0];
  assign in_way    = s_axis_tdata_i[8:6];
  assign accept    = s_axis_tvalid_i && s_axis_tready_o;
  assign slot_free = !m_valid_q || m_axis_tready_i;

  dplru_ram #(
    .WIDTH (ROW_W),
    .DEPTH (SETS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (accept),
    .raddr_i (AW'(in_set)),
    .rdata_o (row)
  );

  // Row after the update; unknown kinds leave it as read.
  always_comb begin
    new_row = row;
    upd_we  = 1'b0;
    case (kind_q)
      dplru_pkg::KIND_TOUCH: begin
        new_row[way_q*EW+DW +: SW] = tick_q;
        upd_we = 1'b1;
      end
      dplru_pkg::KIND_FILL: begin
        new_row[way_q*EW+DW +: SW] = tick_q;
        new_row[way_q*EW +: DW]    = deg_q;
        upd_we = 1'b1;
      end
      dplru_pkg::KIND_INVALIDATE: begin
        new_row[way_q*EW+DW +: SW] = '0;
        upd_we = 1'b1;
      end
      dplru_pkg::KIND_SET_DEGREE: begin
        new_row[way_q*EW +: DW] = deg_q;
        upd_we = 1'b1;
      end
      default: begin
        upd_we = 1'b0;
      end
    endcase
  end

  assign cand_deg   = row[cnt_q*EW +: DW];
  assign cand_stamp = row[cnt_q*EW+DW +: SW];
  assign best_deg   = row[best_q*EW +: DW];
  assign best_stamp = row[best_q*EW+DW +: SW];
  assign better     = (cand_deg < best_deg) ||
                      ((cand_deg == best_deg) && (cand_stamp < best_stamp));
  assign scan_last  = (cnt_q == WIW'(WAYS - 1));

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      dplru_pkg::ST_CLEAR: begin
        if (clr_q == AW'(SETS - 1)) state_d = dplru_pkg::ST_IDLE;
      end
      dplru_pkg::ST_IDLE: begin
        if (s_axis_tvalid_i) state_d = dplru_pkg::ST_EXEC;
      end
      dplru_pkg::ST_EXEC: begin
        if (kind_q == dplru_pkg::KIND_FIND_VICTIM && set_ok_q) begin
          state_d = dplru_pkg::ST_SCAN;
        end else begin
          state_d = dplru_pkg::ST_PUSH;
        end
      end
      dplru_pkg::ST_SCAN: begin
        if (scan_last) state_d = dplru_pkg::ST_PUSH;
      end
      dplru_pkg::ST_PUSH: begin
        if (slot_free) state_d = dplru_pkg::ST_IDLE;
      end
      default: begin
        state_d = dplru_pkg::ST_CLEAR;
      end
    endcase
  end

  // Outputs and datapath control.
  always_comb begin
    s_axis_tready_o = 1'b0;
    we        = 1'b0;
    waddr     = set_q;
    wdata     = new_row;
    clr_d     = clr_q;
    best_d    = best_q;
    cnt_d     = cnt_q;
    res_vic_d = res_vic_q;
    res_old_d = res_old_q;
    m_valid_d = m_valid_q && !m_axis_tready_i;
    m_data_d  = m_data_q;
    case (state_q)
      dplru_pkg::ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
        wdata = '0;
        clr_d = clr_q + AW'(1);
      end
      dplru_pkg::ST_IDLE: begin
        s_axis_tready_o = 1'b1;
      end
      dplru_pkg::ST_EXEC: begin
        we        = set_ok_q && way_ok_q && upd_we;
        res_old_d = (set_ok_q && way_ok_q) ? row[way_q*EW +: DW] : '0;
        res_vic_d = '0;
        best_d    = '0;
        cnt_d     = WIW'(1);
      end
      dplru_pkg::ST_SCAN: begin
        if (better) best_d = cnt_q;
        cnt_d = cnt_q + WIW'(1);
        if (scan_last) res_vic_d = dplru_pkg::WAY_W'(better ? cnt_q : best_q);
      end
      dplru_pkg::ST_PUSH: begin
        if (slot_free) begin
          m_valid_d = 1'b1;
          m_data_d  = {1'b0, res_old_q, res_vic_q};
        end
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= dplru_pkg::ST_CLEAR;
      clr_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q   <= dplru_pkg::kind_e'(s_axis_tuser_i);
      set_q    <= AW'(in_set);
      set_ok_q <= (32'(in_set) < SETS);
      way_ok_q <= (32'(in_way) < WAYS);
      way_q    <= WIW'(in_way);
      deg_q    <= s_axis_tdata_i[12:9];
      tick_q   <= s_axis_tdata_i[44:13];
    end
    best_q    <= best_d;
    cnt_q     <= cnt_d;
    res_vic_q <= res_vic_d;
    res_old_q <= res_old_d;
    m_data_q  <= m_data_d;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  // The memory is only written while clearing or while executing a request.
  a_no_idle_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dplru_pkg::ST_IDLE || state_q == dplru_pkg::ST_SCAN ||
     state_q == dplru_pkg::ST_PUSH) |-> !we)
    else $error("memory written outside clear or execute");

  // An accepted request is executed in the very next cycle.
  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == dplru_pkg::ST_EXEC))
    else $error("accepted request not executed");

  // A new result only appears when handed over from the push state.
  a_result_from_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(state_q == dplru_pkg::ST_PUSH))
    else $error("result appeared outside push state");

  // The scan never compares a way against itself or beyond the set.
  a_scan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dplru_pkg::ST_SCAN) |->
      (cnt_q != '0) && (best_q < cnt_q) && (32'(cnt_q) < WAYS))
    else $error("victim scan index out of range");

endmodule

// File: src/dplru_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module dplru_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
